// File: hw/rtl/peq_pkg.sv
package peq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W        = 16;
  localparam int PRIO_W      = 8;
  localparam int COUNT_W     = 5;

  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 24;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_FIND   = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_DN,
    S_SHIFT_UP,
    S_PLACE,
    S_DONE
  } state_t;

endpackage

// File: hw/rtl/peq_table.sv
module peq_table (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [peq_pkg::IDX_W-1:0]   wr_addr,
  input  peq_pkg::entry_t             wr_data,
  input  logic [peq_pkg::IDX_W-1:0]   rd_addr,
  output peq_pkg::entry_t             rd_data
);

  peq_pkg::entry_t mem [peq_pkg::QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hw/rtl/priority_event_queue.sv
// Sequence: every request is first scanned against all entries; an insert then shifts the
// later entries down (unless it goes at the tail) and places the new entry, a remove shifts
// the entries after the removed one up, and a find, a miss, a duplicate or a full table goes
// straight to the result, which waits while the output is stalled.
// Throughput: one item at a time; the entry memory's single read port and the
// scan/shift sequencer visit one entry per cycle.
// Reset (rst, synchronous) empties the queue and drops any pending result.
module priority_event_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // req_type[1:0], event_id[17:2], event_priority[25:18], zero[31:26]
  input  logic [peq_pkg::S_DATA_W-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // status[1:0], found_id[17:2], entry_count[22:18], zero[23]
  output logic [peq_pkg::M_DATA_W-1:0]  m_tdata
);

  localparam int IW = peq_pkg::IDX_W;
  localparam int CW = peq_pkg::CNT_W;

  peq_pkg::state_t state, state_next;

  logic [1:0]                  req, req_next;
  logic [peq_pkg::ID_W-1:0]    id, id_next;
  logic [peq_pkg::PRIO_W-1:0]  prio, prio_next;
  logic [CW-1:0]               count, count_next;
  logic [CW-1:0]               rd_idx, rd_idx_next;
  logic                        pv, pv_next;
  logic [IW-1:0]               p_addr, p_addr_next;
  logic                        id_hit, id_hit_next;
  logic [IW-1:0]               id_pos, id_pos_next;
  logic                        pos_hit, pos_hit_next;
  logic [CW-1:0]               ins_pos, ins_pos_next;
  logic                        find_hit, find_hit_next;
  logic [peq_pkg::ID_W-1:0]    find_id, find_id_next;
  logic [1:0]                  res_status, res_status_next;
  logic [peq_pkg::ID_W-1:0]    res_found, res_found_next;
  logic                        m_tvalid_next;
  logic [peq_pkg::M_DATA_W-1:0] m_tdata_next;

  logic                        wr_en;
  logic [IW-1:0]               wr_addr;
  peq_pkg::entry_t             wr_data;
  logic [IW-1:0]               rd_addr;
  peq_pkg::entry_t             rd_data;

  logic                        accept;
  logic                        full;
  logic                        scan_done;
  logic                        shdn_done;
  logic                        shup_done;
  logic                        out_load;
  logic [CW-1:0]               rd_dec;
  logic [CW-1:0]               id_pos_inc;

  assign accept     = s_tvalid && s_tready;
  assign full       = (count == CW'(peq_pkg::QUEUE_DEPTH));
  assign scan_done  = (rd_idx == count) && !pv;
  assign shdn_done  = (rd_idx == ins_pos) && !pv;
  assign shup_done  = (rd_idx == count) && !pv;
  assign out_load   = !m_tvalid || m_tready;
  assign rd_dec     = rd_idx - CW'(1);
  assign id_pos_inc = CW'(id_pos) + CW'(1);

  peq_table u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next = state;
    case (state)
      peq_pkg::S_IDLE: begin
        if (s_tvalid) state_next = peq_pkg::S_SCAN;
      end
      peq_pkg::S_SCAN: begin
        if (scan_done) begin
          if (req == peq_pkg::REQ_INSERT) begin
            if (id_hit || full)        state_next = peq_pkg::S_DONE;
            else if (ins_pos == count) state_next = peq_pkg::S_PLACE;
            else                       state_next = peq_pkg::S_SHIFT_DN;
          end else if (req == peq_pkg::REQ_REMOVE && id_hit) begin
            state_next = peq_pkg::S_SHIFT_UP;
          end else begin
            state_next = peq_pkg::S_DONE;
          end
        end
      end
      peq_pkg::S_SHIFT_DN: begin
        if (shdn_done) state_next = peq_pkg::S_PLACE;
      end
      peq_pkg::S_SHIFT_UP: begin
        if (shup_done) state_next = peq_pkg::S_DONE;
      end
      peq_pkg::S_PLACE: begin
        state_next = peq_pkg::S_DONE;
      end
      peq_pkg::S_DONE: begin
        if (out_load) state_next = peq_pkg::S_IDLE;
      end
      default: state_next = peq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_tready        = (state == peq_pkg::S_IDLE);
    req_next        = req;
    id_next         = id;
    prio_next       = prio;
    count_next      = count;
    rd_idx_next     = rd_idx;
    pv_next         = 1'b0;
    p_addr_next     = p_addr;
    id_hit_next     = id_hit;
    id_pos_next     = id_pos;
    pos_hit_next    = pos_hit;
    ins_pos_next    = ins_pos;
    find_hit_next   = find_hit;
    find_id_next    = find_id;
    res_status_next = res_status;
    res_found_next  = res_found;
    m_tvalid_next   = m_tvalid && !m_tready;
    m_tdata_next    = m_tdata;
    wr_en           = 1'b0;
    wr_addr         = p_addr;
    wr_data         = rd_data;
    rd_addr         = rd_idx[IW-1:0];

    case (state)
      peq_pkg::S_IDLE: begin
        if (accept) begin
          req_next      = s_tdata[1:0];
          id_next       = s_tdata[17:2];
          prio_next     = s_tdata[25:18];
          rd_idx_next   = '0;
          id_hit_next   = 1'b0;
          pos_hit_next  = 1'b0;
          find_hit_next = 1'b0;
          ins_pos_next  = count;
        end
      end
      peq_pkg::S_SCAN: begin
        if (rd_idx != count) begin
          rd_addr     = rd_idx[IW-1:0];
          rd_idx_next = rd_idx + CW'(1);
          pv_next     = 1'b1;
          p_addr_next = rd_idx[IW-1:0];
        end
        // Only the first match of each kind counts: queue order decides.
        if (pv) begin
          if (!id_hit && rd_data.id == id) begin
            id_hit_next = 1'b1;
            id_pos_next = p_addr;
          end
          if (!pos_hit && rd_data.prio <= prio) begin
            pos_hit_next = 1'b1;
            ins_pos_next = CW'(p_addr);
          end
          if (!find_hit && rd_data.prio == prio) begin
            find_hit_next = 1'b1;
            find_id_next  = rd_data.id;
          end
        end
        if (scan_done) begin
          res_found_next = '0;
          case (req)
            peq_pkg::REQ_INSERT: begin
              rd_idx_next = count;
              if (id_hit)    res_status_next = peq_pkg::ST_DUP;
              else if (full) res_status_next = peq_pkg::ST_FULL;
              else           res_status_next = peq_pkg::ST_DONE;
            end
            peq_pkg::REQ_REMOVE: begin
              rd_idx_next     = id_pos_inc;
              res_status_next = id_hit ? peq_pkg::ST_DONE : peq_pkg::ST_MISS;
            end
            peq_pkg::REQ_FIND: begin
              res_status_next = find_hit ? peq_pkg::ST_DONE : peq_pkg::ST_MISS;
              if (find_hit) res_found_next = find_id;
            end
            default: res_status_next = peq_pkg::ST_MISS;
          endcase
        end
      end
      peq_pkg::S_SHIFT_DN: begin
        // Read entry k-1 and write it to slot k on the next cycle.
        if (rd_idx != ins_pos) begin
          rd_addr     = rd_dec[IW-1:0];
          rd_idx_next = rd_dec;
          pv_next     = 1'b1;
          p_addr_next = rd_idx[IW-1:0];
        end
        if (pv) wr_en = 1'b1;
      end
      peq_pkg::S_SHIFT_UP: begin
        // Read entry k and write it to slot k-1 on the next cycle.
        if (rd_idx != count) begin
          rd_addr     = rd_idx[IW-1:0];
          rd_idx_next = rd_idx + CW'(1);
          pv_next     = 1'b1;
          p_addr_next = rd_dec[IW-1:0];
        end
        if (pv) wr_en = 1'b1;
        if (shup_done) count_next = count - CW'(1);
      end
      peq_pkg::S_PLACE: begin
        wr_en        = 1'b1;
        wr_addr      = ins_pos[IW-1:0];
        wr_data.id   = id;
        wr_data.prio = prio;
        count_next   = count + CW'(1);
      end
      peq_pkg::S_DONE: begin
        if (out_load) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = {1'b0, peq_pkg::COUNT_W'(count), res_found, res_status};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= peq_pkg::S_IDLE;
      count    <= '0;
      pv       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      pv       <= pv_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    req        <= req_next;
    id         <= id_next;
    prio       <= prio_next;
    rd_idx     <= rd_idx_next;
    p_addr     <= p_addr_next;
    id_hit     <= id_hit_next;
    id_pos     <= id_pos_next;
    pos_hit    <= pos_hit_next;
    ins_pos    <= ins_pos_next;
    find_hit   <= find_hit_next;
    find_id    <= find_id_next;
    res_status <= res_status_next;
    res_found  <= res_found_next;
    m_tdata    <= m_tdata_next;
  end

endmodule

// File: hw/rtl/peq_checker.sv
module peq_assertions (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic [peq_pkg::M_DATA_W-1:0]  m_tdata
);

  logic [1:0]                  out_status;
  logic [peq_pkg::ID_W-1:0]    out_found;
  logic [peq_pkg::COUNT_W-1:0] out_count;

  assign out_status = m_tdata[1:0];
  assign out_found  = m_tdata[17:2];
  assign out_count  = m_tdata[22:18];

  // The block is not ready again right after it takes an item.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready stayed high right after an accepted item");

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_count <= peq_pkg::COUNT_W'(peq_pkg::QUEUE_DEPTH))
    else $error("entry count above queue depth");

  // Only a successful lookup carries an identifier; a full table is really full.
  a_found_only_on_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_status != peq_pkg::ST_DONE |-> out_found == '0)
    else $error("identifier reported with a failing status");

  a_full_means_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_status == peq_pkg::ST_FULL
      |-> out_count == peq_pkg::COUNT_W'(peq_pkg::QUEUE_DEPTH))
    else $error("table full reported below depth");

endmodule

bind priority_event_queue peq_assertions u_peq_assertions (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tdata  (m_tdata)
);
